@@ rtl/kabf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared types and constants of the angle and bias Kalman filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

  typedef struct packed {
    logic signed [24:0] meas_angle;
    logic signed [27:0] meas_rate;
    logic        [16:0] step_time;
  } kabf_in_t;

  typedef struct packed {
    logic signed [31:0] est_angle;
    logic signed [31:0] est_bias;
  } kabf_out_t;

  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  localparam logic [30:0] ANGLE_NOISE_RST   = 31'd268435;
  localparam logic [30:0] BIAS_NOISE_RST    = 31'd805306;
  localparam logic [30:0] MEASURE_NOISE_RST = 31'd8053064;

  localparam int DIV_STEPS = 61;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [34:0] den;
  } kabf_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } kabf_div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

@@ rtl/kabf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_div
// Restoring divider, one quotient bit per cycle, signed truncating result.
// ----------------------------------------------------------------------------
module kabf_div import kabf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  kabf_div_req_t req,
  output kabf_div_rsp_t rsp
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic [60:0] q_r, q_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [34:0] d_r, d_nxt;
  logic [35:0] trial;
  logic [63:0] anum;
  logic [34:0] aden;
  logic signed [62:0] sq;

  assign anum  = req.num[63] ? 64'(-req.num) : req.num;
  assign aden  = req.den[34] ? 35'(-req.den) : req.den;
  assign trial = {rem_r[34:0], q_r[60]} - {1'b0, d_r};
  assign sq    = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(DIV_STEPS);
      neg_nxt  = req.num[63] ^ req.den[34];
      q_nxt    = anum[60:0];
      rem_nxt  = 36'(anum[63:61]);
      d_nxt    = aden;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end else begin
        if (!trial[35]) begin
          rem_nxt = trial;
          q_nxt   = {q_r[59:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[34:0], q_r[60]};
          q_nxt   = {q_r[59:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.done = busy_r && (cnt_r == 6'd0);
  assign rsp.quo  = sat32(66'(sq));

endmodule

@@ rtl/kalman_angle_bias_filter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_core
// Two-state angle and rate bias Kalman filter, fixed point.
// ----------------------------------------------------------------------------
// Input channel in_*: one transaction carries measured angle, rate and time
// step. Output channel out_*: one transaction per input with the new angle
// and bias estimate. Configuration channel cfg_*: writes the three noise
// registers by index; it is always ready and an unknown index is dropped.
// One shared 33x35 multiplier with a 66-bit product runs the whole
// update under a sequencer, one product per cycle except while it waits on
// the divider; the two gains come from a radix-2 divider of 61 steps each.
// in_ready is low from the acceptance of an item until its result is
// taken. The result waits in an output register; in_ready rises again the
// cycle after it is taken, so no new item is accepted before the last
// result is taken, and a stalled receiver holds the block. Reset clears the
// estimates and the covariance to zero, loads the default noise values,
// and leaves the block ready with no pending result.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter_core import kabf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  kabf_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output kabf_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_RATE = 5'd1,  S_ANG  = 5'd2,
                         S_BB   = 5'd3,  S_INN  = 5'd4,  S_AA   = 5'd5,
                         S_AB   = 5'd6,  S_BN   = 5'd7,  S_DIV0 = 5'd8,
                         S_W0   = 5'd9,  S_DIV1 = 5'd10, S_W1   = 5'd11,
                         S_Y    = 5'd12, S_KA   = 5'd13, S_KB   = 5'd14,
                         S_K00  = 5'd15, S_K01  = 5'd16, S_K10  = 5'd17,
                         S_K11  = 5'd18, S_OUT  = 5'd19;

  logic [4:0]  st_r, st_nxt;
  logic [30:0] an_r, bn_r, mn_r;
  logic signed [31:0] ang_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [31:0] rate_r, y_r, k0_r, k1_r, p00_r, p01_r;
  logic signed [32:0] dtbb_r;
  logic signed [34:0] inn_r;
  logic signed [24:0] ma_r;
  logic signed [27:0] mr_r;
  logic [16:0] dt_r;
  logic        ov_r;
  kabf_out_t   od_r;

  logic signed [32:0] ma;
  logic signed [34:0] mb;
  logic signed [65:0] prod;
  logic [4:0]  sh;
  logic signed [65:0] psh;
  kabf_div_req_t dreq;
  kabf_div_rsp_t drsp;

  assign in_ready  = (st_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // shared multiplier operand select
  always_comb begin
    ma = 33'sd0;
    mb = 35'sd0;
    sh = 5'd16;
    unique case (st_r)
      S_ANG:  begin ma = $signed({16'd0, dt_r}); mb = 35'(rate_r); end
      S_BB:   begin ma = $signed({16'd0, dt_r}); mb = 35'(bb_r);   end
      S_AA:   begin ma = $signed({16'd0, dt_r}); mb = inn_r;       end
      S_BN:   begin ma = $signed({16'd0, dt_r}); mb = $signed({4'b0, bn_r}); end
      S_KA:   begin ma = 33'(k0_r); mb = 35'(y_r);   sh = 5'd28; end
      S_KB:   begin ma = 33'(k1_r); mb = 35'(y_r);   sh = 5'd28; end
      S_K00:  begin ma = 33'(k0_r); mb = 35'(p00_r); sh = 5'd28; end
      S_K01:  begin ma = 33'(k0_r); mb = 35'(p01_r); sh = 5'd28; end
      S_K10:  begin ma = 33'(k1_r); mb = 35'(p00_r); sh = 5'd28; end
      S_K11:  begin ma = 33'(k1_r); mb = 35'(p01_r); sh = 5'd28; end
      default: begin end
    endcase
  end

  assign prod = ma * mb;
  assign psh  = prod >>> sh;

  assign dreq.start = (st_r == S_DIV0) || (st_r == S_DIV1);
  assign dreq.num   = (st_r == S_DIV0) ? (64'(aa_r) <<< 28) : (64'(ba_r) <<< 28);
  assign dreq.den   = 35'(aa_r) + 35'($signed({1'b0, mn_r}));

  kabf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_valid && in_ready) st_nxt = S_RATE;
      S_RATE: st_nxt = S_ANG;
      S_ANG:  st_nxt = S_BB;
      S_BB:   st_nxt = S_INN;
      S_INN:  st_nxt = S_AA;
      S_AA:   st_nxt = S_AB;
      S_AB:   st_nxt = S_BN;
      S_BN:   st_nxt = S_DIV0;
      S_DIV0: st_nxt = S_W0;
      S_W0:   if (drsp.done) st_nxt = S_DIV1;
      S_DIV1: st_nxt = S_W1;
      S_W1:   if (drsp.done) st_nxt = S_Y;
      S_Y:    st_nxt = S_KA;
      S_KA:   st_nxt = S_KB;
      S_KB:   st_nxt = S_K00;
      S_K00:  st_nxt = S_K01;
      S_K01:  st_nxt = S_K10;
      S_K10:  st_nxt = S_K11;
      S_K11:  st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ov_r   <= 1'b0;
      an_r   <= ANGLE_NOISE_RST;
      bn_r   <= BIAS_NOISE_RST;
      mn_r   <= MEASURE_NOISE_RST;
      ang_r  <= '0;
      bias_r <= '0;
      aa_r   <= '0;
      ab_r   <= '0;
      ba_r   <= '0;
      bb_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ANGLE_NOISE:   an_r <= cfg_wdata[30:0];
          REG_BIAS_NOISE:    bn_r <= cfg_wdata[30:0];
          REG_MEASURE_NOISE: mn_r <= cfg_wdata[30:0];
          default: begin end
        endcase
      end
      if (out_valid && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_ANG: ang_r <= sat32(66'(ang_r) + psh);
        S_AA:  aa_r  <= sat32(66'(aa_r) + psh);
        S_AB:  begin
          ab_r <= sat32(66'(ab_r) - 66'(dtbb_r));
          ba_r <= sat32(66'(ba_r) - 66'(dtbb_r));
        end
        S_BN:  bb_r <= sat32(66'(bb_r) + psh);
        S_KA:  ang_r  <= sat32(66'(ang_r) + psh);
        S_KB:  bias_r <= sat32(66'(bias_r) + psh);
        S_K00: aa_r <= sat32(66'(aa_r) - psh);
        S_K01: ab_r <= sat32(66'(ab_r) - psh);
        S_K10: ba_r <= sat32(66'(ba_r) - psh);
        S_K11: bb_r <= sat32(66'(bb_r) - psh);
        S_OUT: ov_r <= 1'b1;
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ma_r <= in_data.meas_angle;
      mr_r <= in_data.meas_rate;
      dt_r <= in_data.step_time;
    end
    case (st_r)
      S_RATE: rate_r <= sat32(66'(mr_r) - 66'(bias_r));
      S_BB:   dtbb_r <= psh[32:0];
      S_INN:  inn_r  <= 35'(dtbb_r) - 35'(ab_r) - 35'(ba_r)
                        + 35'($signed({1'b0, an_r}));
      S_DIV1: k0_r <= (dreq.den == 35'sd0) ? 32'sd0 : drsp.quo;
      S_Y:    begin
        k1_r  <= (dreq.den == 35'sd0) ? 32'sd0 : drsp.quo;
        y_r   <= sat32(66'(ma_r) - 66'(ang_r));
        p00_r <= aa_r;
        p01_r <= ab_r;
      end
      S_OUT:  begin
        od_r.est_angle <= ang_r;
        od_r.est_bias  <= bias_r;
      end
      default: begin end
    endcase
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == S_OUT) else $error("result without sequence");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r && $stable(od_r)) else $error("result dropped");

endmodule
